// ===== rtl/c3wgs_pkg.sv =====
// Shared widths, configuration register indexes and pixel and accumulator types of the 3x3 filter.
`timescale 1ns / 1ps

package c3wgs_pkg;

	localparam int PX_W       = 16;
	localparam int COEF_W     = 16;
	localparam int KCOLS      = 3;
	localparam int KROWS      = 3;
	localparam int TAPS       = KROWS * KCOLS;
	localparam int ROW_W      = KCOLS * COEF_W;
	localparam int ACC_W      = 32;
	localparam int GAIN_W     = 16;
	localparam int OUT_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = ROW_W;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEFF_TOP = 3'd0,
		REG_COEFF_MID = 3'd1,
		REG_COEFF_BOT = 3'd2,
		REG_GAIN      = 3'd3,
		REG_MAG_MODE  = 3'd4
	} cfg_reg_t;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

	typedef logic signed [PX_W-1:0]  px_t;
	typedef logic signed [ACC_W-1:0] acc_t;

endpackage

// ===== rtl/c3wgs_win_if.sv =====
// Window and result channel interfaces of the 3x3 filter.
`timescale 1ns / 1ps

interface c3wgs_win_if import c3wgs_pkg::*; ();
	logic valid;
	logic ready;
	px_t  px_r0_c0;
	px_t  px_r0_c1;
	px_t  px_r0_c2;
	px_t  px_r1_c0;
	px_t  px_r1_c1;
	px_t  px_r1_c2;
	px_t  px_r2_c0;
	px_t  px_r2_c1;
	px_t  px_r2_c2;

	modport source (
		output valid, px_r0_c0, px_r0_c1, px_r0_c2, px_r1_c0, px_r1_c1, px_r1_c2,
		       px_r2_c0, px_r2_c1, px_r2_c2,
		input  ready
	);
	modport sink (
		input  valid, px_r0_c0, px_r0_c1, px_r0_c2, px_r1_c0, px_r1_c1, px_r1_c2,
		       px_r2_c0, px_r2_c1, px_r2_c2,
		output ready
	);
endinterface

interface c3wgs_pix_if import c3wgs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] filtered_pixel;

	modport source (output valid, filtered_pixel, input ready);
	modport sink   (input valid, filtered_pixel, output ready);
endinterface

// ===== rtl/conv3x3_window_gain_saturate_unit.sv =====
// Top level: pipelined 3x3 window correlation with gain, shift and unsigned saturation.
`timescale 1ns / 1ps

// One 3x3 window of signed 16-bit pixels is taken per clock and one unsigned
// 16-bit pixel comes out per window, in order. The path is a six-stage
// pipeline (nine products, row sums, total, optional absolute value, gain
// multiply, shift and clamp). A window's result is offered on the result
// channel from the last stage register and leaves once the output side is
// ready. Throughput is one window per cycle while the result channel is
// ready; back-pressure on the result channel stalls the stages that are full
// and nothing is dropped or repeated. Coefficient rows, gain and magnitude
// mode are written through cfg_we/cfg_idx/cfg_wdata while no window is in
// flight; indexes beyond the register list are ignored.
module conv3x3_window_gain_saturate_unit import c3wgs_pkg::*; #(
	parameter int GAIN_SHIFT = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	c3wgs_win_if.sink             win,
	c3wgs_pix_if.source           pix
);

	// Configuration registers
	logic [ROW_W-1:0]  coef_row_q [KROWS];
	logic [GAIN_W-1:0] gain_q;
	logic              mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < KROWS; r++) coef_row_q[r] <= '0;
			gain_q <= GAIN_RESET;
			mag_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_COEFF_TOP: coef_row_q[0] <= cfg_wdata[ROW_W-1:0];
				REG_COEFF_MID: coef_row_q[1] <= cfg_wdata[ROW_W-1:0];
				REG_COEFF_BOT: coef_row_q[2] <= cfg_wdata[ROW_W-1:0];
				REG_GAIN:      gain_q <= cfg_wdata[GAIN_W-1:0];
				REG_MAG_MODE:  mag_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Gather window pixels in row-major order
	px_t px_w [TAPS];
	assign px_w[0] = win.px_r0_c0;
	assign px_w[1] = win.px_r0_c1;
	assign px_w[2] = win.px_r0_c2;
	assign px_w[3] = win.px_r1_c0;
	assign px_w[4] = win.px_r1_c1;
	assign px_w[5] = win.px_r1_c2;
	assign px_w[6] = win.px_r2_c0;
	assign px_w[7] = win.px_r2_c1;
	assign px_w[8] = win.px_r2_c2;

	// Stage valids and advance enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6;

	assign adv_s6 = !vld_s6 || pix.ready;
	assign adv_s5 = !vld_s5 || adv_s6;
	assign adv_s4 = !vld_s4 || adv_s5;
	assign adv_s3 = !vld_s3 || adv_s4;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign win.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= win.valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
			if (adv_s6) vld_s6 <= vld_s5;
		end
	end

	// Stage 1: nine pixel-by-coefficient products
	acc_t prod_w [TAPS];
	acc_t prod_s1 [TAPS];

	always_comb begin
		for (int t = 0; t < TAPS; t++) begin
			prod_w[t] = px_w[t] * $signed(coef_row_q[t / KCOLS][(t % KCOLS) * COEF_W +: COEF_W]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && win.valid) begin
			for (int t = 0; t < TAPS; t++) prod_s1[t] <= prod_w[t];
		end
	end

	// Stage 2: row sums, wrapping at the accumulator width
	acc_t rsum_s2 [KROWS];

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			for (int r = 0; r < KROWS; r++) begin
				rsum_s2[r] <= prod_s1[r*KCOLS] + prod_s1[r*KCOLS+1] + prod_s1[r*KCOLS+2];
			end
		end
	end

	// Stage 3: window total
	acc_t tot_s3;

	always_ff @(posedge clk) begin
		if (adv_s3 && vld_s2) tot_s3 <= rsum_s2[0] + rsum_s2[1] + rsum_s2[2];
	end

	// Stage 4: absolute value in magnitude mode; the most negative total wraps to itself
	acc_t abs_s4;

	always_ff @(posedge clk) begin
		if (adv_s4 && vld_s3) abs_s4 <= (mag_q && tot_s3[ACC_W-1]) ? -tot_s3 : tot_s3;
	end

	// Stage 5: gain multiply, keep the low accumulator bits
	logic signed [ACC_W+GAIN_W-1:0] gprod_w;
	acc_t                           gprod_s5;

	assign gprod_w = abs_s4 * $signed(gain_q);

	always_ff @(posedge clk) begin
		if (adv_s5 && vld_s4) gprod_s5 <= gprod_w[ACC_W-1:0];
	end

	// Stage 6: arithmetic shift and clamp to the unsigned output range
	acc_t             scaled_w;
	logic [OUT_W-1:0] sat_w;
	logic [OUT_W-1:0] pix_s6;

	assign scaled_w = gprod_s5 >>> GAIN_SHIFT;

	always_comb begin
		if (scaled_w[ACC_W-1])
			sat_w = '0;
		else if (|scaled_w[ACC_W-2:OUT_W])
			sat_w = '1;
		else
			sat_w = scaled_w[OUT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv_s6 && vld_s5) pix_s6 <= sat_w;
	end

	assign pix.valid          = vld_s6;
	assign pix.filtered_pixel = pix_s6;

	// Checks
	a_stall_implies_full: assert property (@(posedge clk) disable iff (!arst_n)
		!win.ready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6))
		else $error("input stalled while a stage is empty");

	a_transfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(win.valid && win.ready) |=> vld_s1)
		else $error("accepted window did not enter stage 1");

	a_row_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !adv_s2) |=> (vld_s2 && $stable(rsum_s2[0]) && $stable(rsum_s2[2])))
		else $error("stalled row sums changed");

	a_abs_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && mag_q && abs_s4 != {1'b1, {(ACC_W-1){1'b0}}}) |-> !abs_s4[ACC_W-1])
		else $error("magnitude result negative");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the 3x3 window filter with gain and unsigned saturation.
`timescale 1ns / 1ps

module tb;
	import c3wgs_pkg::*;

	localparam int GAIN_SHIFT   = 8;
	localparam int WIN_W        = TAPS * PX_W;
	localparam int DRAIN_CYCLES = 10;
	localparam int QUIET_LIMIT  = 2000;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 250;
	localparam int MAX_REPORTS  = 10;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_MAG_MODE + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

	// One row of the directed plan: a register write or a window
	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [WIN_W-1:0]      w;
		bit                    typed;
		logic [OUT_W-1:0]      want;
	} plan_row_t;

	// Per offered window: expected pixel typed in, or left to the predictor
	typedef struct {
		bit               typed;
		logic [OUT_W-1:0] want;
	} window_tag_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	c3wgs_win_if win_ch ();
	c3wgs_pix_if pix_ch ();

	conv3x3_window_gain_saturate_unit #(
		.GAIN_SHIFT (GAIN_SHIFT)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.win       (win_ch),
		.pix       (pix_ch)
	);

	// Shadow copy of the configuration registers
	logic [ROW_W-1:0]         coef_row [KROWS];
	logic signed [GAIN_W-1:0] gain_q;
	logic                     mag_q;

	logic [OUT_W-1:0] pixel_expect_q [$];
	window_tag_t      window_tag_q [$];
	plan_row_t        plan_q [$];

	int err_cnt;
	int quiet_cycles;
	int gap_odds;
	int stall_odds;

	window_tag_t      seen_tag;
	logic [OUT_W-1:0] seen_want;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Correlate window with kernel, optional abs, gain, shift, clamp to unsigned
	function automatic logic [OUT_W-1:0] filter_pixel(logic [WIN_W-1:0] w);
		acc_t sum;
		acc_t pel;
		acc_t coef;
		acc_t scaled;
		sum = '0;
		for (int i = 0; i < TAPS; i++) begin
			pel  = acc_t'(px_t'(w[PX_W*i +: PX_W]));
			coef = acc_t'(px_t'(coef_row[i / KCOLS][COEF_W*(i % KCOLS) +: COEF_W]));
			sum  = sum + pel * coef;
		end
		if (mag_q && sum[ACC_W-1])
			sum = -sum;
		scaled = (sum * acc_t'(gain_q)) >>> GAIN_SHIFT;
		if (scaled < 0)
			return '0;
		if (scaled > 65535)
			return '1;
		return scaled[OUT_W-1:0];
	endfunction

	function automatic logic [WIN_W-1:0] tap(int i, logic [PX_W-1:0] v);
		return WIN_W'(v) << (PX_W * i);
	endfunction

	function automatic logic [PX_W-1:0] pick_extreme();
		case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	// Mix of full-range, extreme and small values
	function automatic logic [PX_W-1:0] rand_px();
		case ($urandom_range(0, 3))
			0: return PX_W'($urandom);
			1: return pick_extreme();
			default: return PX_W'($urandom_range(0, 16)) - 16'd8;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_gain_word();
		logic [GAIN_W-1:0] g;
		case ($urandom_range(0, 3))
			0: g = pick_extreme();
			1: g = 16'd256 + GAIN_W'($urandom_range(0, 64)) - 16'd32;
			2: g = GAIN_W'($urandom);
			default: g = GAIN_W'($urandom_range(0, 16));
		endcase
		// Junk above the field width must be ignored
		return {GAIN_W'($urandom), GAIN_W'($urandom), g};
	endfunction

	function automatic void plan_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		plan_q.push_back('{1'b1, idx, data, '0, 1'b0, '0});
	endfunction

	function automatic void plan_win(logic [WIN_W-1:0] w, bit typed, logic [OUT_W-1:0] want);
		plan_q.push_back('{1'b0, '0, '0, w, typed, want});
	endfunction

	// Write one register once nothing is in flight, and track it in the shadow copy
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		win_ch.valid <= 1'b0;
		while (pixel_expect_q.size() != 0 || window_tag_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_COEFF_TOP: coef_row[0] = data;
			REG_COEFF_MID: coef_row[1] = data;
			REG_COEFF_BOT: coef_row[2] = data;
			REG_GAIN:      gain_q = data[GAIN_W-1:0];
			REG_MAG_MODE:  mag_q = data[0];
			default: ;
		endcase
	endtask

	// Offer one window, with an optional idle burst first; return at its transfer
	task automatic send_window(logic [WIN_W-1:0] w, bit typed, logic [OUT_W-1:0] want);
		int gap;
		gap = 0;
		if (gap_odds != 0 && $urandom_range(0, 2 * gap_odds) == 0)
			gap = $urandom_range(1, 11);
		if (gap != 0) begin
			win_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		window_tag_q.push_back('{typed, want});
		win_ch.valid    <= 1'b1;
		win_ch.px_r0_c0 <= w[PX_W*0 +: PX_W];
		win_ch.px_r0_c1 <= w[PX_W*1 +: PX_W];
		win_ch.px_r0_c2 <= w[PX_W*2 +: PX_W];
		win_ch.px_r1_c0 <= w[PX_W*3 +: PX_W];
		win_ch.px_r1_c1 <= w[PX_W*4 +: PX_W];
		win_ch.px_r1_c2 <= w[PX_W*5 +: PX_W];
		win_ch.px_r2_c0 <= w[PX_W*6 +: PX_W];
		win_ch.px_r2_c1 <= w[PX_W*7 +: PX_W];
		win_ch.px_r2_c2 <= w[PX_W*8 +: PX_W];
		do @(posedge clk); while (!win_ch.ready);
	endtask

	task automatic flag_error(string what, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
		err_cnt++;
		if (err_cnt <= MAX_REPORTS)
			$display("%0t: %s filtered_pixel expected %0d got %0d", $realtime, what, want, got);
	endtask

	// Record expectations on window transfers, check results on pixel transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (win_ch.valid && win_ch.ready) begin
				seen_tag = window_tag_q.pop_front();
				if (seen_tag.typed)
					pixel_expect_q.push_back(seen_tag.want);
				else
					pixel_expect_q.push_back(filter_pixel({
						win_ch.px_r2_c2, win_ch.px_r2_c1, win_ch.px_r2_c0,
						win_ch.px_r1_c2, win_ch.px_r1_c1, win_ch.px_r1_c0,
						win_ch.px_r0_c2, win_ch.px_r0_c1, win_ch.px_r0_c0}));
			end
			if (pix_ch.valid && pix_ch.ready) begin
				if (pixel_expect_q.size() == 0) begin
					flag_error("unexpected result:", '0, pix_ch.filtered_pixel);
				end else begin
					seen_want = pixel_expect_q.pop_front();
					if (pix_ch.filtered_pixel !== seen_want)
						flag_error("mismatch:", seen_want, pix_ch.filtered_pixel);
				end
			end
		end
	end

	// End the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((win_ch.valid && win_ch.ready) || (pix_ch.valid && pix_ch.ready) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL conv3x3_window_gain_saturate_unit");
			$finish;
		end
	end

	// Result side: ready in random runs, with stall bursts while stalls are enabled
	initial begin
		pix_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			pix_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			if (stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
				pix_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	initial begin
		logic [WIN_W-1:0] w;
		plan_row_t        row;

		arst_n          = 1'b0;
		cfg_we          <= 1'b0;
		cfg_idx         <= '0;
		cfg_wdata       <= '0;
		win_ch.valid    <= 1'b0;
		win_ch.px_r0_c0 <= '0;
		win_ch.px_r0_c1 <= '0;
		win_ch.px_r0_c2 <= '0;
		win_ch.px_r1_c0 <= '0;
		win_ch.px_r1_c1 <= '0;
		win_ch.px_r1_c2 <= '0;
		win_ch.px_r2_c0 <= '0;
		win_ch.px_r2_c1 <= '0;
		win_ch.px_r2_c2 <= '0;
		err_cnt      = 0;
		quiet_cycles = 0;
		gap_odds     = 2;
		stall_odds   = 2;
		for (int r = 0; r < KROWS; r++)
			coef_row[r] = '0;
		gain_q = GAIN_RESET;
		mag_q  = 1'b0;

		// Reset values: zero kernel gives zero
		plan_win({TAPS{16'h7FFF}}, 1'b1, 16'd0);
		plan_win({TAPS{16'h8000}}, 1'b1, 16'd0);
		// Center tap alone, unit gain after the shift
		plan_cfg(REG_COEFF_MID, 48'h0000_0001_0000);
		plan_win(tap(4, 16'h7FFF), 1'b1, 16'd32767);
		plan_win(tap(4, 16'h8000), 1'b1, 16'd0);
		plan_win(tap(4, 16'h0001), 1'b1, 16'd1);
		plan_win({TAPS{16'hFFFF}}, 1'b1, 16'd0);
		// Largest gain, junk above the gain field
		plan_cfg(REG_GAIN, 48'hABCD_1234_7FFF);
		plan_win(tap(4, 16'h0001), 1'b1, 16'd127);
		plan_win(tap(4, 16'h7FFF), 1'b1, 16'd65535);
		// Most negative gain
		plan_cfg(REG_GAIN, 48'h0000_0000_8000);
		plan_win(tap(4, 16'hFFFF), 1'b1, 16'd128);
		plan_win(tap(4, 16'h0002), 1'b1, 16'd0);
		plan_win(tap(4, 16'h8000), 1'b1, 16'd65535);
		// Magnitude mode folds negative sums
		plan_cfg(REG_MAG_MODE, 48'hFFFF_FFFF_FFFF);
		plan_cfg(REG_GAIN, 48'h0000_0000_0100);
		plan_win(tap(4, 16'hFFFB), 1'b1, 16'd5);
		plan_win(tap(4, 16'h8000), 1'b1, 16'd32768);
		// Writes past the register list leave everything alone
		plan_cfg(REG_FIRST_UNUSED, '1);
		plan_cfg(REG_LAST_UNUSED, '0);
		plan_win(tap(4, 16'h0003), 1'b1, 16'd3);
		// Sum of exactly -2^31 stays negative under abs
		plan_cfg(REG_COEFF_TOP, 48'h0000_0000_8000);
		plan_cfg(REG_COEFF_MID, 48'h0000_0000_8000);
		plan_cfg(REG_GAIN, 48'h0000_0000_0001);
		plan_win(tap(0, 16'h8000) | tap(3, 16'h8000), 1'b1, 16'd0);
		plan_win(tap(0, 16'h8000) | tap(3, 16'h7FFF), 1'b1, 16'd128);
		// Gain product wraps past 32 bits
		plan_cfg(REG_GAIN, 48'h0000_0000_7FFF);
		plan_win(tap(0, 16'h8000), 1'b0, '0);
		plan_win(tap(0, 16'd1000) | tap(3, 16'd77), 1'b0, '0);
		// Full kernel at the extremes
		plan_cfg(REG_COEFF_TOP, 48'h8000_8000_8000);
		plan_cfg(REG_COEFF_MID, 48'h8000_8000_8000);
		plan_cfg(REG_COEFF_BOT, 48'h8000_8000_8000);
		plan_cfg(REG_GAIN, 48'h0000_0000_0100);
		plan_cfg(REG_MAG_MODE, 48'h0000_0000_0000);
		plan_win({TAPS{16'h8000}}, 1'b0, '0);
		plan_win({TAPS{16'h7FFF}}, 1'b0, '0);
		plan_cfg(REG_COEFF_BOT, 48'h7FFF_7FFF_7FFF);
		plan_cfg(REG_MAG_MODE, 48'h0000_0000_0001);
		plan_win({TAPS{16'h7FFF}}, 1'b0, '0);
		plan_win({TAPS{16'h0001}}, 1'b0, '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed plan
		foreach (plan_q[i]) begin
			row = plan_q[i];
			if (row.is_cfg)
				write_reg(row.idx, row.data);
			else
				send_window(row.w, row.typed, row.want);
		end

		// Random phases: fresh settings, then random windows
		for (int p = 0; p < RAND_PHASES; p++) begin
			for (int r = 0; r < KROWS; r++)
				write_reg(REG_COEFF_TOP + CFG_IDX_W'(r), {rand_px(), rand_px(), rand_px()});
			write_reg(REG_GAIN, rand_gain_word());
			write_reg(REG_MAG_MODE, {CFG_DATA_W'({$urandom, $urandom})});
			if ($urandom_range(0, 1) == 1)
				write_reg(REG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 2)),
					{CFG_DATA_W'({$urandom, $urandom})});
			// Hold both sides busy for the last phase
			if (p == RAND_PHASES - 1) begin
				gap_odds   = 0;
				stall_odds = 0;
			end else begin
				gap_odds   = $urandom_range(0, 3);
				stall_odds = $urandom_range(0, 3);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				for (int t = 0; t < TAPS; t++)
					w[PX_W*t +: PX_W] = rand_px();
				send_window(w, 1'b0, '0);
			end
		end

		// Drain, then allow the pipeline latency
		win_ch.valid <= 1'b0;
		while (pixel_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("PASS conv3x3_window_gain_saturate_unit");
		else
			$display("FAIL conv3x3_window_gain_saturate_unit");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/c3wgs_pkg.sv
rtl/c3wgs_win_if.sv
rtl/conv3x3_window_gain_saturate_unit.sv
bench/tb.sv
